[rtl/core/cls_pkg.sv]
// Shared types and constants of the compacting list store.
package cls_pkg;

	localparam int CAPACITY_DEF = 16;

	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_REMOVE = 2'd1;
	localparam logic [1:0] ACT_READ   = 2'd2;

	typedef struct packed {
		logic load;
		logic append;
		logic rd_pos;
		logic scan;
		logic move;
		logic dec;
		logic finish;
		logic ok;
		logic ret;
	} cmd_t;

	typedef struct packed {
		logic [1:0] action;
		logic       full;
		logic       empty;
		logic       pos_ok;
		logic       hit;
		logic       scan_end;
		logic       src_live;
	} status_t;

endpackage

[rtl/core/cls_datapath.sv]
// Entry memory, fill count, walk index and result registers of the list store.
module cls_datapath #(
	parameter int CAPACITY = cls_pkg::CAPACITY_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [1:0]          action,
	input  logic signed [31:0]  value,
	input  logic [3:0]          position,
	input  cls_pkg::cmd_t       cmd,
	output cls_pkg::status_t    status,
	output logic                done,
	output logic                ok,
	output logic signed [31:0]  read_value,
	output logic [4:0]          count,
	output logic                is_empty,
	output logic                is_full
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY + 2);

	logic [31:0]        mem [CAPACITY];
	logic [1:0]         action_q;
	logic signed [31:0] value_q;
	logic [3:0]         pos_q;
	logic [CW-1:0]      cnt_q;
	logic [IW-1:0]      idx_q;
	logic [31:0]        rdata_q;
	logic               done_q;
	logic               ok_q;
	logic signed [31:0] rval_q;
	logic [CW+4:0]      cnt_ext;
	logic               rd_en;
	logic [AW-1:0]      raddr;

	always_comb begin
		rd_en = 1'b0;
		raddr = AW'(idx_q);
		if (cmd.rd_pos) begin
			rd_en = 1'b1;
			raddr = AW'(pos_q);
		end else if (cmd.scan || cmd.move) begin
			rd_en = (32'(idx_q) < 32'(cnt_q));
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem[raddr];
		end
		if (cmd.append) begin
			mem[AW'(cnt_q)] <= value_q;
		end else if (cmd.move) begin
			mem[AW'(idx_q - IW'(2))] <= rdata_q;
		end
		if (cmd.load) begin
			action_q <= action;
			value_q  <= value;
			pos_q    <= position;
		end
		if (cmd.finish) begin
			ok_q   <= cmd.ok;
			rval_q <= cmd.ret ? signed'(rdata_q) : 32'sd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			idx_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (cmd.append) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (cmd.dec) begin
				cnt_q <= cnt_q - CW'(1);
			end
			if (cmd.load) begin
				idx_q <= '0;
			end else if (cmd.scan || cmd.move) begin
				idx_q <= idx_q + IW'(1);
			end
		end
	end

	always_comb begin
		status.action   = action_q;
		status.full     = (32'(cnt_q) == 32'(CAPACITY));
		status.empty    = (cnt_q == '0);
		status.pos_ok   = (32'(pos_q) < 32'(cnt_q)) && (32'(pos_q) < 32'(CAPACITY));
		status.hit      = (signed'(rdata_q) == value_q);
		status.scan_end = (32'(idx_q) == 32'(cnt_q));
		status.src_live = (32'(idx_q) <= 32'(cnt_q));
	end

	assign cnt_ext    = {5'd0, cnt_q};
	assign done       = done_q;
	assign ok         = ok_q;
	assign read_value = rval_q;
	assign count      = cnt_ext[4:0];
	assign is_empty   = (cnt_q == '0);
	assign is_full    = (32'(cnt_q) == 32'(CAPACITY));

endmodule

[rtl/core/cls_ctrl.sv]
// Controller state machine of the list store.
module cls_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  cls_pkg::status_t    status,
	output cls_pkg::cmd_t       cmd,
	output logic                busy
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_EXEC   = 3'd1;
	localparam logic [2:0] S_RDWAIT = 3'd2;
	localparam logic [2:0] S_SEARCH = 3'd3;
	localparam logic [2:0] S_SHIFT  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				unique case (status.action)
					cls_pkg::ACT_INSERT: begin
						cmd.finish = 1'b1;
						if (!status.full) begin
							cmd.append = 1'b1;
							cmd.ok     = 1'b1;
						end
						state_d = S_IDLE;
					end
					cls_pkg::ACT_REMOVE: begin
						if (status.empty) begin
							cmd.finish = 1'b1;
							state_d    = S_IDLE;
						end else begin
							cmd.scan = 1'b1;
							state_d  = S_SEARCH;
						end
					end
					cls_pkg::ACT_READ: begin
						if (status.pos_ok) begin
							cmd.rd_pos = 1'b1;
							state_d    = S_RDWAIT;
						end else begin
							cmd.finish = 1'b1;
							state_d    = S_IDLE;
						end
					end
					default: begin
						cmd.finish = 1'b1;
						state_d    = S_IDLE;
					end
				endcase
			end
			S_RDWAIT: begin
				cmd.finish = 1'b1;
				cmd.ok     = 1'b1;
				cmd.ret    = 1'b1;
				state_d    = S_IDLE;
			end
			S_SEARCH: begin
				if (status.hit) begin
					cmd.scan = 1'b1;
					state_d  = S_SHIFT;
				end else if (status.scan_end) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end else begin
					cmd.scan = 1'b1;
				end
			end
			S_SHIFT: begin
				if (status.src_live) begin
					cmd.move = 1'b1;
				end else begin
					cmd.dec    = 1'b1;
					cmd.finish = 1'b1;
					cmd.ok     = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

[rtl/core/compacting_list_store_unit.sv]
// Compacting list store: a packed list of signed 32-bit values in one
// memory of CAPACITY entries. A beat is taken when start is high and busy
// is low; its result appears for exactly one cycle with done high and
// cannot be held off, so the receiver must take it then. Insert, an
// unknown action and a failed empty or position check finish from the
// execute state, a good read from a read-wait state after it. Remove
// walks the memory one entry a cycle through its single read port,
// first searching for the value and then moving each later entry down
// one place. A new beat may be taken in the cycle that done is shown.
module compacting_list_store_unit #(
	parameter int CAPACITY = cls_pkg::CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         action,
	input  logic signed [31:0] value,
	input  logic [3:0]         position,
	output logic               done,
	output logic               ok,
	output logic signed [31:0] read_value,
	output logic [4:0]         count,
	output logic               is_empty,
	output logic               is_full
);

	cls_pkg::cmd_t    cmd;
	cls_pkg::status_t status;

	cls_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	cls_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.action     (action),
		.value      (value),
		.position   (position),
		.cmd        (cmd),
		.status     (status),
		.done       (done),
		.ok         (ok),
		.read_value (read_value),
		.count      (count),
		.is_empty   (is_empty),
		.is_full    (is_full)
	);

endmodule

[tb/compacting_list_store_unit_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the compacting list store: directed and random list traffic.
module compacting_list_store_unit_test;

	import cls_pkg::*;

	localparam int         CAP         = CAPACITY_DEF;
	localparam logic [1:0] ACT_UNUSED  = 2'd3;
	localparam int         CYCLE_LIMIT = 200000;
	localparam int         TAIL_CYCLES = 40;

	typedef struct packed {
		logic               ok;
		logic signed [31:0] rd;
		logic [4:0]         cnt;
		logic               empty;
		logic               full;
	} list_result_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         action;
	logic signed [31:0] value;
	logic [3:0]         position;
	logic               done;
	logic               ok;
	logic signed [31:0] read_value;
	logic [4:0]         count;
	logic               is_empty;
	logic               is_full;

	logic signed [31:0] shadow_entries [CAP];
	int                 shadow_count;
	list_result_t       pending_results [$];
	int                 errors;
	int                 cycle_count;
	bit                 gaps_on;

	compacting_list_store_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.action     (action),
		.value      (value),
		.position   (position),
		.done       (done),
		.ok         (ok),
		.read_value (read_value),
		.count      (count),
		.is_empty   (is_empty),
		.is_full    (is_full)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Apply one operation to the shadow list and return the result it should give.
	task automatic apply_list_op(input logic [1:0] op, input logic signed [31:0] v,
		input logic [3:0] pos, output list_result_t r);
		int hit;
		r = '0;
		hit = -1;
		case (op)
			ACT_INSERT: begin
				if (shadow_count < CAP) begin
					shadow_entries[shadow_count] = v;
					shadow_count++;
					r.ok = 1'b1;
				end
			end
			ACT_REMOVE: begin
				for (int i = 0; i < shadow_count; i++)
					if (hit < 0 && shadow_entries[i] == v)
						hit = i;
				if (hit >= 0) begin
					for (int i = hit + 1; i < shadow_count; i++)
						shadow_entries[i - 1] = shadow_entries[i];
					shadow_count--;
					r.ok = 1'b1;
				end
			end
			ACT_READ: begin
				if (pos < shadow_count) begin
					r.rd = shadow_entries[pos];
					r.ok = 1'b1;
				end
			end
			default: ;
		endcase
		r.cnt   = 5'(shadow_count);
		r.empty = (shadow_count == 0);
		r.full  = (shadow_count == CAP);
	endtask

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin : check_beat
		list_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none actual ok %0b value %0d count %0d",
					$time, ok, read_value, count);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if ({ok, read_value, count, is_empty, is_full} !== want)
					$display("%0t: beat expected %h actual %h", $time, want,
						{ok, read_value, count, is_empty, is_full});
				check_field("ok", want.ok, ok);
				check_field("read_value", want.rd, read_value);
				check_field("count", want.cnt, count);
				check_field("is_empty", want.empty, is_empty);
				check_field("is_full", want.full, is_full);
			end
		end
	end

	task automatic issue_op(input logic [1:0] op, input logic signed [31:0] v,
		input logic [3:0] pos);
		list_result_t r;
		if (gaps_on && $urandom_range(99) < 25) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start    <= 1'b1;
		action   <= op;
		value    <= v;
		position <= pos;
		do @(posedge clk); while (busy);
		apply_list_op(op, v, pos, r);
		pending_results.push_back(r);
	endtask

	task automatic wait_for_results();
		start <= 1'b0;
		do @(negedge clk); while (pending_results.size() != 0);
		@(posedge clk);
	endtask

	function automatic logic signed [31:0] pick_value();
		int sel;
		sel = $urandom_range(99);
		if (sel < 50)
			return $signed(32'($urandom_range(7))) - 4;
		if (sel < 70) begin
			case ($urandom_range(3))
				0:       return 32'sh8000_0000;
				1:       return 32'sh7fff_ffff;
				2:       return 32'sd0;
				default: return -32'sd1;
			endcase
		end
		return $signed($urandom);
	endfunction

	task automatic test_empty_list();
		issue_op(ACT_REMOVE, 32'sd5, 4'd0);
		issue_op(ACT_READ, 32'sd0, 4'd0);
		issue_op(ACT_READ, 32'sd0, 4'd15);
		issue_op(ACT_UNUSED, -32'sd1, 4'd15);
		wait_for_results();
	endtask

	task automatic test_fill_and_overflow();
		logic signed [31:0] v;
		for (int i = 0; i < CAP; i++) begin
			case (i)
				0:       v = 32'sh8000_0000;
				1:       v = 32'sh7fff_ffff;
				2:       v = 32'sd0;
				3:       v = -32'sd1;
				default: v = 32'(i % 3) + 32'sd10;
			endcase
			issue_op(ACT_INSERT, v, 4'(i));
		end
		issue_op(ACT_INSERT, 32'sd42, 4'd0);
		issue_op(ACT_READ, 32'sd0, 4'd15);
		wait_for_results();
	endtask

	task automatic test_remove_cases();
		issue_op(ACT_REMOVE, 32'sd11, 4'd0);
		issue_op(ACT_REMOVE, 32'sh8000_0000, 4'd0);
		issue_op(ACT_REMOVE, 32'sd99, 4'd0);
		issue_op(ACT_READ, 32'sd0, 4'd13);
		wait_for_results();
	endtask

	// Alternate between filling and draining phases so both full and empty recur.
	task automatic test_random_traffic(input int n);
		int ins_w;
		int sel;
		logic [3:0] pos;
		ins_w = 60;
		for (int k = 0; k < n; k++) begin
			if (k % 40 == 0)
				ins_w = (ins_w == 60) ? 15 : 60;
			sel = $urandom_range(99);
			pos = 4'($urandom_range(15));
			if (sel < 3) begin
				issue_op(ACT_UNUSED, $signed($urandom), pos);
			end else if (sel < 3 + ins_w) begin
				issue_op(ACT_INSERT, pick_value(), pos);
			end else if (sel < 3 + ins_w + 20) begin
				if (shadow_count > 0 && $urandom_range(99) < 80)
					pos = 4'($urandom_range(shadow_count - 1));
				issue_op(ACT_READ, $signed($urandom), pos);
			end else if (shadow_count > 0 && $urandom_range(99) < 70) begin
				issue_op(ACT_REMOVE, shadow_entries[$urandom_range(shadow_count - 1)], pos);
			end else begin
				issue_op(ACT_REMOVE, pick_value(), pos);
			end
		end
		wait_for_results();
	endtask

	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		action       = ACT_INSERT;
		value        = '0;
		position     = '0;
		shadow_count = 0;
		errors       = 0;
		cycle_count  = 0;
		gaps_on      = 1'b1;
		for (int i = 0; i < CAP; i++)
			shadow_entries[i] = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		test_empty_list();
		test_fill_and_overflow();
		test_remove_cases();
		test_random_traffic(450);
		gaps_on = 1'b0;
		test_random_traffic(100);

		wait_for_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

[sim.f]
rtl/core/cls_pkg.sv
rtl/core/cls_datapath.sv
rtl/core/cls_ctrl.sv
rtl/core/compacting_list_store_unit.sv
tb/compacting_list_store_unit_test.sv
